// ----- sv/hkam_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkam_pkg: shared types and constants of the hotkey action matcher
// Holds the table geometry, the operation and result codes, the word that
// travels along the cell chain and the modifier key decode.
// ----------------------------------------------------------------------------
package hkam_pkg;

    // Table and device geometry.
    localparam int ACTIONS = 16;
    localparam int DEVICES = 16;

    // Only sixteen entries and sixteen devices can be addressed by the fields.
    localparam int CELLS     = (ACTIONS < 16) ? ACTIONS : 16;
    localparam int MOD_DEPTH = (DEVICES < 16) ? DEVICES : 16;
    localparam int DEV_W     = (MOD_DEPTH > 1) ? $clog2(MOD_DEPTH) : 1;

    // Input func codes.
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_EVENT  = 2'd1;
    localparam logic [1:0] FUNC_EXPIRE = 2'd2;

    // Event values.
    localparam logic [1:0] VAL_RELEASE = 2'd0;
    localparam logic [1:0] VAL_PRESS   = 2'd1;

    // Result kinds.
    localparam logic [1:0] KIND_FIRE   = 2'd0;
    localparam logic [1:0] KIND_ARMED  = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACTION_COUNT = 2'd0;
    localparam logic [1:0] REG_HOLD_TICKS   = 2'd1;
    localparam logic [1:0] REG_LONG_TICKS   = 2'd2;

    // Entry mode bit positions.
    localparam int ENTRY_CTRL_BIT = 0;
    localparam int ENTRY_ALT_BIT  = 1;
    localparam int ENTRY_HOLD_BIT = 2;
    localparam int ENTRY_LONG_BIT = 3;

    // Modifier key codes.
    localparam logic [9:0] KEY_LCTRL = 10'd29;
    localparam logic [9:0] KEY_RCTRL = 10'd97;
    localparam logic [9:0] KEY_LALT  = 10'd56;
    localparam logic [9:0] KEY_RALT  = 10'd100;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_EXPIRE,
        OP_PRESS,
        OP_RELEASE
    } op_t;

    // Word handed from cell to cell.
    typedef struct packed {
        op_t         op;
        logic [10:0] code;
        logic [3:0]  dev;
        logic [1:0]  cur;
        logic [3:0]  mode;
        logic [3:0]  idx;
    } evt_t;

    // Result offered by the cell that holds the word.
    typedef struct packed {
        logic        hit;
        logic [3:0]  idx;
        logic [1:0]  kind;
        logic [15:0] ticks;
    } res_t;

    // Bit of the per-device modifier state that a key code controls.
    function automatic logic [3:0] modifier_bit(input logic [9:0] code);
        logic [3:0] b;
        unique case (code)
            KEY_LCTRL: b = 4'b0001;
            KEY_RCTRL: b = 4'b0010;
            KEY_LALT:  b = 4'b0100;
            KEY_RALT:  b = 4'b1000;
            default:   b = 4'b0000;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/hotkey_action_matcher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotkey_action_matcher_top: hotkey matcher over a chain of table cells
// Results: a result passes from its cell into the pending register and then
//   into the output register, where it is held while the output stalls.
// Input: a new input word is taken only after the previous word has left the
//   chain and its pending result has moved on to the output register.
// Reset: asynchronous and active low; clears holds, modifiers and control
//   state and loads the register defaults 0, 100 and 1000.
// ----------------------------------------------------------------------------
// Each accepted word that does anything is turned into a chain word and
// enters the first cell. It moves one cell per cycle unless the chain is frozen;
// the cell that holds it compares the word against its entry, updates its hold
// state and may offer one result. Since only one word is in flight, at most one
// cell offers a result per cycle, and the offers are merged by a plain OR.
//
// A result is first parked in a pending register. It moves on to the output
// register when the next result arrives (not last) or when the chain has
// drained (last). This lets the block mark the final result without looking
// ahead. When a new result arrives while both registers are full and the
// output is stalled, the whole chain freezes for that cycle.
//
// The modifier state of the reporting device is read and updated when the
// word is accepted. The table walk reads only the ctrl/alt summary taken at
// that point, so doing the update early gives the same answers as doing it
// after the walk.
// ----------------------------------------------------------------------------
module hotkey_action_matcher_top (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [3:0]  device,
    input  logic        is_switch,
    input  logic [9:0]  key_code,
    input  logic [1:0]  value,
    input  logic [3:0]  entry_index,
    input  logic        need_ctrl,
    input  logic        need_alt,
    input  logic        hold_mode,
    input  logic        long_hold,

    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  action_index,
    output logic [1:0]  kind,
    output logic [15:0] hold_time,
    output logic        last
);

    localparam int CELLS = hkam_pkg::CELLS;
    localparam logic [4:0] CELLS_CNT = 5'(CELLS);

    // Configuration registers.
    logic [4:0]  action_count_reg;
    logic [15:0] hold_ticks_reg;
    logic [15:0] long_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_count_reg <= 5'd0;
            hold_ticks_reg   <= 16'd100;
            long_ticks_reg   <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hkam_pkg::REG_ACTION_COUNT: action_count_reg <= cfg_data[4:0];
                hkam_pkg::REG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data;
                hkam_pkg::REG_LONG_TICKS:   long_ticks_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // A zero hold time loads one so that the hold stays armed.
    logic [15:0] hold_t;
    logic [15:0] long_t;
    logic [4:0]  used_cnt;

    assign hold_t   = (hold_ticks_reg == '0) ? 16'd1 : hold_ticks_reg;
    assign long_t   = (long_ticks_reg == '0) ? 16'd1 : long_ticks_reg;
    assign used_cnt = (action_count_reg > CELLS_CNT) ? CELLS_CNT : action_count_reg;

    // Input acceptance and decode.
    logic           any_valid;
    logic           pend_valid_reg;
    logic           accept;
    logic           idx_ok;
    logic           dev_ok;
    logic           launch;
    hkam_pkg::evt_t launch_evt;
    logic [3:0]     mods;
    logic [3:0]     mod_bit;
    logic [hkam_pkg::DEV_W-1:0] dev_sel;

    logic [3:0] mods_reg [hkam_pkg::MOD_DEPTH];

    assign in_stall = any_valid | pend_valid_reg;
    assign accept   = in_valid & ~in_stall;
    assign idx_ok   = (32'(entry_index) < 32'(hkam_pkg::ACTIONS));
    assign dev_ok   = (32'(device) < 32'(hkam_pkg::DEVICES));
    assign dev_sel  = device[hkam_pkg::DEV_W-1:0];
    assign mods     = mods_reg[dev_sel];
    assign mod_bit  = hkam_pkg::modifier_bit(key_code);

    always_comb
    begin
        launch_evt.code = {is_switch, key_code};
        launch_evt.dev  = device;
        launch_evt.cur  = {|mods[3:2], |mods[1:0]};
        launch_evt.mode = {long_hold, hold_mode, need_alt, need_ctrl};
        launch_evt.idx  = entry_index;
        launch          = 1'b0;
        priority if (func == hkam_pkg::FUNC_WRITE)
        begin
            launch_evt.op = hkam_pkg::OP_WRITE;
            launch        = accept & idx_ok;
        end
        else if (func == hkam_pkg::FUNC_EXPIRE)
        begin
            launch_evt.op = hkam_pkg::OP_EXPIRE;
            launch        = accept & idx_ok;
        end
        else if (value == hkam_pkg::VAL_PRESS)
        begin
            launch_evt.op = hkam_pkg::OP_PRESS;
            launch        = accept & dev_ok & (func == hkam_pkg::FUNC_EVENT);
        end
        else
        begin
            launch_evt.op = hkam_pkg::OP_RELEASE;
            launch        = accept & dev_ok & (func == hkam_pkg::FUNC_EVENT) &
                            (value == hkam_pkg::VAL_RELEASE);
        end
    end

    // Modifier keys of a key event update the device state at acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < hkam_pkg::MOD_DEPTH; d++)
            begin
                mods_reg[d] <= '0;
            end
        end
        else if (launch && !is_switch && (launch_evt.op == hkam_pkg::OP_PRESS))
        begin
            mods_reg[dev_sel] <= mods | mod_bit;
        end
        else if (launch && !is_switch && (launch_evt.op == hkam_pkg::OP_RELEASE))
        begin
            mods_reg[dev_sel] <= mods & ~mod_bit;
        end
    end

    // Cell chain. Link 0 is the word being launched.
    logic           adv;
    logic           evt_v [CELLS+1];
    hkam_pkg::evt_t evt_w [CELLS+1];
    hkam_pkg::res_t res_w [CELLS];
    hkam_pkg::res_t cur;

    assign evt_v[0] = launch;
    assign evt_w[0] = launch_evt;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        hkam_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .adv            (adv),
            .in_use         (5'(i) < used_cnt),
            .cell_idx       (4'(i)),
            .hold_t         (hold_t),
            .long_t         (long_t),
            .evt_valid_prev (evt_v[i]),
            .evt_prev       (evt_w[i]),
            .evt_valid      (evt_v[i+1]),
            .evt            (evt_w[i+1]),
            .res            (res_w[i])
        );
    end

    // At most one cell holds the word, so the offers merge by OR.
    always_comb
    begin
        cur       = '0;
        any_valid = 1'b0;
        for (int i = 0; i < CELLS; i++)
        begin
            cur       = hkam_pkg::res_t'(cur | res_w[i]);
            any_valid = any_valid | evt_v[i+1];
        end
    end

    // Pending and output registers.
    hkam_pkg::res_t pend_reg;
    logic           out_valid_reg;
    logic [3:0]     act_idx_reg;
    logic [1:0]     kind_reg;
    logic [15:0]    ticks_reg;
    logic           last_reg;
    logic           out_free;
    logic           take_new;
    logic           flush_take;
    logic           out_load;

    assign out_free   = ~out_valid_reg | ~out_stall;
    assign adv        = ~(cur.hit & pend_valid_reg & ~out_free);
    assign take_new   = cur.hit & adv;
    assign flush_take = ~any_valid & pend_valid_reg & out_free;
    assign out_load   = (take_new & pend_valid_reg) | flush_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= take_new | (pend_valid_reg & ~flush_take);
            out_valid_reg  <= out_load | (out_valid_reg & out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            act_idx_reg <= pend_reg.idx;
            kind_reg    <= pend_reg.kind;
            ticks_reg   <= pend_reg.ticks;
            last_reg    <= flush_take;
        end
        if (take_new)
        begin
            pend_reg <= cur;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action_index = act_idx_reg;
    assign kind         = kind_reg;
    assign hold_time    = ticks_reg;
    assign last         = last_reg;

endmodule

// ----- sv/hkam_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkam_cell: one table entry of the hotkey matcher
// Holds one entry and its hold state, checks the word in its stage against
// the entry and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module hkam_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_use,
    input  logic [3:0]       cell_idx,
    input  logic [15:0]      hold_t,
    input  logic [15:0]      long_t,
    input  logic             evt_valid_prev,
    input  hkam_pkg::evt_t   evt_prev,
    output logic             evt_valid,
    output hkam_pkg::evt_t   evt,
    output hkam_pkg::res_t   res
);

    logic           evt_valid_reg;
    hkam_pkg::evt_t evt_reg;

    logic [10:0] code_reg,  code_next;
    logic [3:0]  mode_reg,  mode_next;
    logic [15:0] armed_reg, armed_next;
    logic [3:0]  hdev_reg,  hdev_next;

    logic sel;
    logic code_eq;

    assign sel     = (evt_reg.idx == cell_idx);
    assign code_eq = (code_reg == evt_reg.code);

    always_comb
    begin
        code_next  = code_reg;
        mode_next  = mode_reg;
        armed_next = armed_reg;
        hdev_next  = hdev_reg;
        res        = '0;
        if (evt_valid_reg)
        begin
            unique case (evt_reg.op)
                hkam_pkg::OP_WRITE:
                begin
                    if (sel)
                    begin
                        code_next  = evt_reg.code;
                        mode_next  = evt_reg.mode;
                        armed_next = '0;
                        hdev_next  = '0;
                    end
                end
                hkam_pkg::OP_EXPIRE:
                begin
                    if (sel && (armed_reg != '0))
                    begin
                        armed_next = '0;
                        hdev_next  = '0;
                        res.hit    = 1'b1;
                        res.idx    = cell_idx;
                        res.kind   = hkam_pkg::KIND_FIRE;
                    end
                end
                hkam_pkg::OP_PRESS:
                begin
                    if (in_use && code_eq && (mode_reg[1:0] == evt_reg.cur))
                    begin
                        res.hit = 1'b1;
                        res.idx = cell_idx;
                        if (mode_reg[hkam_pkg::ENTRY_HOLD_BIT])
                        begin
                            res.kind  = hkam_pkg::KIND_ARMED;
                            res.ticks = mode_reg[hkam_pkg::ENTRY_LONG_BIT] ? long_t : hold_t;
                            armed_next = res.ticks;
                            hdev_next  = evt_reg.dev;
                        end
                        else
                        begin
                            res.kind = hkam_pkg::KIND_FIRE;
                        end
                    end
                end
                hkam_pkg::OP_RELEASE:
                begin
                    if (in_use && (armed_reg != '0) && code_eq && (hdev_reg == evt_reg.dev))
                    begin
                        armed_next = '0;
                        hdev_next  = '0;
                        res.hit    = 1'b1;
                        res.idx    = cell_idx;
                        res.kind   = hkam_pkg::KIND_CANCEL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            armed_reg     <= '0;
            hdev_reg      <= '0;
        end
        else if (adv)
        begin
            evt_valid_reg <= evt_valid_prev;
            if (evt_valid_reg)
            begin
                armed_reg <= armed_next;
                hdev_reg  <= hdev_next;
            end
        end
    end

    // Entry contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            evt_reg <= evt_prev;
            if (evt_valid_reg)
            begin
                code_reg <= code_next;
                mode_reg <= mode_next;
            end
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

// ----- sv/hkam_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkam_checker: port-level checks of the hotkey action matcher
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module hkam_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  func,
    input logic [3:0]  entry_index,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  action_index,
    input logic [1:0]  kind,
    input logic [15:0] hold_time,
    input logic        last
);

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action_index) &&
        $stable(kind) && $stable(hold_time) && $stable(last))
        else $error("stalled result word changed");

    // A table write keeps the block busy while it walks the chain.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == hkam_pkg::FUNC_WRITE) &&
        (32'(entry_index) < 32'(hkam_pkg::ACTIONS)) |=> in_stall)
        else $error("table write did not occupy the chain");

    // While a result other than the last waits, more results are on the way.
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input taken before all results of a word were sent");

    // Only an armed hold carries a time, and it is never zero.
    a_time_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == hkam_pkg::KIND_ARMED) == (hold_time != 16'd0)))
        else $error("hold time does not match result kind");

endmodule

bind hotkey_action_matcher_top hkam_checker u_hkam_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .entry_index  (entry_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .action_index (action_index),
    .kind         (kind),
    .hold_time    (hold_time),
    .last         (last)
);
